/* hdl/bafp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bafp_pkg
// Shared types, constants and the arctangent constant generator for the
// bearing angle core.
// ----------------------------------------------------------------------------
package bafp_pkg;

  // Default configuration
  localparam int COORD_WIDTH_DEF   = 16;
  localparam int ANGLE_FRAC_DEF    = 7;
  localparam int BEARING_WIDTH     = 16;

  // Internal fixed-point formats
  localparam int RAD_FRAC          = 61;   // radians, fraction bits
  localparam int DEG_FRAC          = 48;   // degrees, fraction bits
  localparam int N_ITER            = 61;   // rotation cells
  localparam int NORM_MSB          = 60;   // normalized magnitude MSB
  localparam int MUL_SHIFT         = 71;   // Q61 * Q58 -> Q48
  localparam logic [63:0] RAD2DEG_Q58 = 64'd16514384080961256899;
  localparam logic [63:0] DEG_90      = 64'd90 << DEG_FRAC;
  localparam logic [63:0] DEG_45      = 64'd45 << DEG_FRAC;

  // Quadrant and special-case flags that ride along the pipeline
  typedef struct packed {
    logic zero_pt;   // both differences zero
    logic oct_zero;  // minor component zero
    logic oct_diag;  // components equal
    logic swap;      // |dy| > |dx|
    logic dx_neg;
    logic dy_neg;
  } side_t;

  // Rotation datapath word
  typedef struct packed {
    logic        valid;
    side_t       side;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] z;
    logic        neg;
  } cord_t;

  // Octant angle in degrees, Q48
  typedef struct packed {
    logic        valid;
    side_t       side;
    logic [63:0] phi;
  } phi_t;

  // 2^sh / k, truncated, by restoring long division (elaboration only)
  function automatic logic [63:0] pow2_div(input int sh, input int k);
    logic [63:0] q;
    logic [7:0]  r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[6:0], (b == sh)};
      if (r >= k[7:0]) begin
        r = r - k[7:0];
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in Q61 radians from its Taylor series
  function automatic logic [63:0] atan_entry(input int i);
    logic [63:0] s;
    int          k;
    s = '0;
    for (int n = 0; n < 32; n++) begin
      k = 2 * n + 1;
      if (i * k <= RAD_FRAC) begin
        if ((n & 1) != 0) begin
          s = s - pow2_div(RAD_FRAC - i * k, k);
        end else begin
          s = s + pow2_div(RAD_FRAC - i * k, k);
        end
      end
    end
    return s;
  endfunction

endpackage

/* hdl/bafp_prep.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bafp_prep
// Forms the coordinate differences, folds them into the first octant and
// normalizes the magnitudes for the rotation chain. Three stages.
// ----------------------------------------------------------------------------
module bafp_prep #(
  parameter int COORD_WIDTH = bafp_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          valid_i,
  input  logic signed [COORD_WIDTH-1:0] sensor_x_i,
  input  logic signed [COORD_WIDTH-1:0] sensor_y_i,
  input  logic signed [COORD_WIDTH-1:0] target_x_i,
  input  logic signed [COORD_WIDTH-1:0] target_y_i,
  output bafp_pkg::cord_t               q_o
);
  import bafp_pkg::*;

  localparam int MW = COORD_WIDTH + 1;   // magnitude width
  localparam int SW = $clog2(MW);        // MSB index width

  // Stage 1: differences and magnitudes
  logic signed [MW-1:0] dx, dy;
  logic [MW-1:0]        ax_nxt, ay_nxt;
  logic [MW-1:0]        ax_r, ay_r;
  logic                 dxn_r, dyn_r, s1_valid_r;

  assign dx = {target_x_i[COORD_WIDTH-1], target_x_i}
            - {sensor_x_i[COORD_WIDTH-1], sensor_x_i};
  assign dy = {target_y_i[COORD_WIDTH-1], target_y_i}
            - {sensor_y_i[COORD_WIDTH-1], sensor_y_i};
  assign ax_nxt = dx[MW-1] ? (~dx + 1'b1) : dx;
  assign ay_nxt = dy[MW-1] ? (~dy + 1'b1) : dy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= valid_i;
      ax_r       <= ax_nxt;
      ay_r       <= ay_nxt;
      dxn_r      <= dx[MW-1];
      dyn_r      <= dy[MW-1];
    end
  end

  // Stage 2: octant fold, special cases, leading-one position
  logic          swap;
  logic [MW-1:0] p, q;
  logic [SW-1:0] msb;
  side_t         side_nxt;
  logic [MW-1:0] p_r, q_r;
  logic [SW-1:0] msb_r;
  side_t         side_r;
  logic          s2_valid_r;

  assign swap = ay_r > ax_r;
  assign p    = swap ? ay_r : ax_r;
  assign q    = swap ? ax_r : ay_r;

  always_comb begin
    msb = '0;
    for (int i = 0; i < MW; i++) begin
      if (p[i]) msb = SW'(i);
    end
  end

  always_comb begin
    side_nxt.zero_pt  = (p == '0);
    side_nxt.oct_zero = (q == '0);
    side_nxt.oct_diag = (q == p);
    side_nxt.swap     = swap;
    side_nxt.dx_neg   = dxn_r;
    side_nxt.dy_neg   = dyn_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
      p_r        <= p;
      q_r        <= q;
      msb_r      <= msb;
      side_r     <= side_nxt;
    end
  end

  // Stage 3: shift so the major component has its MSB at bit 60
  logic [5:0] sh;
  cord_t      q_nxt, out_r;

  assign sh = 6'(NORM_MSB) - 6'(msb_r);

  always_comb begin
    q_nxt.valid = s2_valid_r;
    q_nxt.side  = side_r;
    q_nxt.x     = 64'(p_r) << sh;
    q_nxt.y     = 64'(q_r) << sh;
    q_nxt.z     = '0;
    q_nxt.neg   = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (en) begin
      out_r <= q_nxt;
    end
  end

  assign q_o = out_r;

endmodule

/* hdl/bafp_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bafp_cell
// One vectoring rotation step: shift by the cell index, add or subtract,
// accumulate the matching arctangent constant.
// ----------------------------------------------------------------------------
module bafp_cell #(
  parameter int IDX = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  bafp_pkg::cord_t d_i,
  output bafp_pkg::cord_t q_o
);
  import bafp_pkg::*;

  localparam logic [63:0] ATAN_K = atan_entry(IDX);

  logic [63:0] xs, ys;
  cord_t       q_nxt, q_r;

  assign xs = d_i.x >> IDX;
  assign ys = d_i.y >> IDX;

  // y is kept as a magnitude; the sign lives in neg
  always_comb begin
    q_nxt       = d_i;
    q_nxt.z     = d_i.neg ? (d_i.z - ATAN_K) : (d_i.z + ATAN_K);
    q_nxt.x     = d_i.x + ys;
    if (d_i.y >= xs) begin
      q_nxt.y   = d_i.y - xs;
    end else begin
      q_nxt.y   = xs - d_i.y;
      q_nxt.neg = !d_i.neg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q_o = q_r;

endmodule

/* hdl/bafp_scale.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bafp_scale
// Converts the accumulated Q61 radian angle to Q48 degrees with a 64x64
// product built from four 32-bit partial products over three stages.
// ----------------------------------------------------------------------------
module bafp_scale (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  bafp_pkg::cord_t d_i,
  output bafp_pkg::phi_t  q_o
);
  import bafp_pkg::*;

  localparam logic [31:0] C_LO = RAD2DEG_Q58[31:0];
  localparam logic [31:0] C_HI = RAD2DEG_Q58[63:32];

  // Stage 1: clamp negative angle, low-half partial products
  logic [63:0] zc;
  logic [31:0] m1_zlo_r;
  logic [30:0] m1_zhi_r;
  logic [63:0] m1_pa_r;
  logic [62:0] m1_pb_r;
  side_t       m1_side_r;
  logic        m1_valid_r;

  assign zc = d_i.z[63] ? 64'd0 : d_i.z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_valid_r <= 1'b0;
    end else if (en) begin
      m1_valid_r <= d_i.valid;
      m1_side_r  <= d_i.side;
      m1_zlo_r   <= zc[31:0];
      m1_zhi_r   <= zc[62:32];
      m1_pa_r    <= zc[31:0] * C_LO;
      m1_pb_r    <= zc[62:32] * C_LO;
    end
  end

  // Stage 2: fold low half, high-half partial products
  logic [95:0] m2_s1_r;
  logic [63:0] m2_pc_r;
  logic [62:0] m2_pd_r;
  side_t       m2_side_r;
  logic        m2_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_valid_r <= 1'b0;
    end else if (en) begin
      m2_valid_r <= m1_valid_r;
      m2_side_r  <= m1_side_r;
      m2_s1_r    <= 96'(m1_pa_r) + (96'(m1_pb_r) << 32);
      m2_pc_r    <= m1_zlo_r * C_HI;
      m2_pd_r    <= m1_zhi_r * C_HI;
    end
  end

  // Stage 3: final sum, keep Q48 degrees
  logic [127:0] prod;
  phi_t         q_nxt, q_r;

  assign prod = 128'(m2_s1_r) + (128'(m2_pc_r) << 32) + (128'(m2_pd_r) << 64);

  always_comb begin
    q_nxt.valid = m2_valid_r;
    q_nxt.side  = m2_side_r;
    q_nxt.phi   = 64'(prod[127:MUL_SHIFT]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q_o = q_r;

endmodule

/* hdl/bafp_post.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bafp_post
// Applies exact special cases, unfolds the octant angle to the full circle,
// rounds to the output step and wraps a full turn to zero.
// ----------------------------------------------------------------------------
module bafp_post #(
  parameter int ANGLE_FRACTION_BITS = bafp_pkg::ANGLE_FRAC_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  bafp_pkg::phi_t                      d_i,
  output logic                                valid_o,
  output logic [bafp_pkg::BEARING_WIDTH-1:0]  bearing_o
);
  import bafp_pkg::*;

  localparam int          SHR  = DEG_FRAC - ANGLE_FRACTION_BITS;
  localparam logic [63:0] HALF = 64'd1 << (SHR - 1);
  localparam logic [63:0] TURN = 64'd360 << ANGLE_FRACTION_BITS;
  localparam logic [63:0] D180 = DEG_90 << 1;
  localparam logic [63:0] D360 = DEG_90 << 2;

  logic [63:0] oct, phi, full, rnd;
  logic [BEARING_WIDTH-1:0] bearing_nxt, bearing_r;
  logic        valid_r;

  // Exact octant answers for axis and diagonal
  always_comb begin
    if (d_i.side.oct_zero) begin
      oct = '0;
    end else if (d_i.side.oct_diag) begin
      oct = DEG_45;
    end else begin
      oct = d_i.phi;
    end
    phi = d_i.side.swap ? (DEG_90 - oct) : oct;
  end

  // Quadrant unfold
  always_comb begin
    if (!d_i.side.dx_neg && !d_i.side.dy_neg) begin
      full = phi;
    end else if (d_i.side.dx_neg && !d_i.side.dy_neg) begin
      full = D180 - phi;
    end else if (d_i.side.dx_neg) begin
      full = D180 + phi;
    end else begin
      full = D360 - phi;
    end
  end

  // Round to nearest, wrap 360 to 0
  always_comb begin
    rnd = (full + HALF) >> SHR;
    if (rnd >= TURN) rnd = rnd - TURN;
    bearing_nxt = d_i.side.zero_pt ? '0 : rnd[BEARING_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r   <= d_i.valid;
      bearing_r <= bearing_nxt;
    end
  end

  assign valid_o   = valid_r;
  assign bearing_o = bearing_r;

endmodule

/* hdl/bearing_angle_from_points_core.sv */
`timescale 1ns / 1ps
// Throughput: one transaction per cycle, set by the 61-cell rotation chain that
//   advances whenever the skid entry is free; a stalled result is held in an output
//   register plus one skid entry, and input stalls only when the skid entry is full.
// Reset: synchronous, active low; clears all valid bits, out_valid and the skid flag.
// ----------------------------------------------------------------------------
// bearing_angle_from_points_core
// Bearing from a sensor point to a target point in degrees (fixed point),
// computed by a pipelined vectoring rotation chain.
// ----------------------------------------------------------------------------
module bearing_angle_from_points_core #(
  parameter int COORD_WIDTH         = bafp_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_FRACTION_BITS = bafp_pkg::ANGLE_FRAC_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [COORD_WIDTH-1:0]      in_sensor_x,
  input  logic signed [COORD_WIDTH-1:0]      in_sensor_y,
  input  logic signed [COORD_WIDTH-1:0]      in_target_x,
  input  logic signed [COORD_WIDTH-1:0]      in_target_y,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bafp_pkg::BEARING_WIDTH-1:0] out_bearing
);
  import bafp_pkg::*;

  logic                     en;
  cord_t                    chain [0:N_ITER];
  phi_t                     scaled;
  logic                     post_valid;
  logic [BEARING_WIDTH-1:0] post_bearing;

  // Output register and skid entry state
  logic                     out_valid_r, skid_full_r, take;
  logic [BEARING_WIDTH-1:0] out_bearing_r, skid_r;

  // Whole pipeline advances while the skid entry is free
  assign en = !skid_full_r;

  bafp_prep #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid_i   (in_valid),
    .sensor_x_i(in_sensor_x),
    .sensor_y_i(in_sensor_y),
    .target_x_i(in_target_x),
    .target_y_i(in_target_y),
    .q_o       (chain[0])
  );

  // Rotation chain
  for (genvar i = 1; i <= N_ITER; i++) begin : g_cell
    bafp_cell #(
      .IDX(i)
    ) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (en),
      .d_i  (chain[i-1]),
      .q_o  (chain[i])
    );
  end

  bafp_scale u_scale (
    .clk  (clk),
    .rst_n(rst_n),
    .en   (en),
    .d_i  (chain[N_ITER]),
    .q_o  (scaled)
  );

  bafp_post #(
    .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)
  ) u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .d_i      (scaled),
    .valid_o  (post_valid),
    .bearing_o(post_bearing)
  );

  // Output register and skid entry
  assign take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (skid_full_r) begin
      if (take) begin
        out_bearing_r <= skid_r;
        skid_full_r   <= 1'b0;
      end
    end else if (post_valid) begin
      if (!out_valid_r || take) begin
        out_bearing_r <= post_bearing;
        out_valid_r   <= 1'b1;
      end else begin
        skid_r      <= post_bearing;
        skid_full_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  assign in_stall    = skid_full_r;
  assign out_valid   = out_valid_r;
  assign out_bearing = out_bearing_r;

endmodule

/* hdl/bafp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bafp_checker
// Port-level checks for the bearing core, attached by bind.
// ----------------------------------------------------------------------------
module bafp_checker #(
  parameter int ANGLE_FRACTION_BITS = bafp_pkg::ANGLE_FRAC_DEF
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [bafp_pkg::BEARING_WIDTH-1:0] out_bearing
);
  import bafp_pkg::*;

  localparam logic [31:0] TURN      = 32'd360 << ANGLE_FRACTION_BITS;
  localparam logic        TURN_FITS = (ANGLE_FRACTION_BITS <= 7);

  // Result is always inside one turn (checked only when a turn fits the bearing width)
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!TURN_FITS || (32'(out_bearing) < TURN)))
    else $error("bearing outside one turn");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_bearing))
    else $error("stalled result changed");

  // Input backpressure only follows a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && $past(out_valid && out_stall))
    else $error("input stalled without output backpressure");

  // Nothing comes out right after reset
  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid && !in_stall)
    else $error("output or stall active after reset");

endmodule

bind bearing_angle_from_points_core bafp_checker #(
  .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)
) u_bafp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_bearing(out_bearing)
);
